// ----- src/ucs_pkg.sv -----
// Shared constants and types for the UCB1 child select block.
package ucs_pkg;

    localparam int MAX_CHILDREN_DEF = 64;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int GAMES_W     = 16;
    localparam int IDX_OUT_W   = 6;
    localparam int TIES_OUT_W  = 7;
    localparam int SEED_W      = 32;
    localparam int TOTAL_W     = 22;
    localparam int NORM_W      = 32;
    localparam int EXP_W       = 5;
    localparam int SQ_ITERS    = 40;
    localparam int L_W         = EXP_W + SQ_ITERS;
    localparam int ITER_CNT_W  = 6;
    localparam int LN2_W       = 64;

    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic [LN2_W-1:0]  LN2_Q64    = 64'hB172_17F7_D1CF_79AB;

    typedef struct packed {
        logic busy;
        logic done;
    } ucs_unit_stat_t;

endpackage

// ----- src/ucs_ifs.sv -----
// Valid/ready channel interfaces for child words and result words.
interface ucs_child_if;
    logic                           valid;
    logic                           ready;
    logic [ucs_pkg::GAMES_W-1:0]    games_played;
    logic [ucs_pkg::GAMES_W-1:0]    games_won;
    logic                           minimize;
    logic                           last;

    modport source (output valid, games_played, games_won, minimize, last, input ready);
    modport sink (input valid, games_played, games_won, minimize, last, output ready);
endinterface

interface ucs_result_if;
    logic                           valid;
    logic                           ready;
    logic [ucs_pkg::IDX_OUT_W-1:0]  chosen_index;
    logic [ucs_pkg::TIES_OUT_W-1:0] tie_count;

    modport source (output valid, chosen_index, tie_count, input ready);
    modport sink (input valid, chosen_index, tie_count, output ready);
endinterface

// ----- src/ucs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ucs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/ucs_div.sv -----
// Restoring divider, one quotient bit per cycle, shared for all divisions.
module ucs_div #(
    parameter int DW = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DW-1:0]                 dividend,
    input  logic [ucs_pkg::GAMES_W-1:0]   divisor,
    output logic [DW-1:0]                 quotient,
    output logic [ucs_pkg::GAMES_W-1:0]   remainder,
    output ucs_pkg::ucs_unit_stat_t       stat
);
    import ucs_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]      q_reg, q_next;
    logic [GAMES_W-1:0] d_reg, d_next;
    logic [GAMES_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [GAMES_W:0]   shifted;
    logic [GAMES_W:0]   diff;
    logic               ge;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[DW-1]};
        diff      = shifted - {1'b0, d_reg};
        ge        = shifted >= {1'b0, d_reg};
        q_next    = q_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            d_next    = divisor;
            rem_next  = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DW-2:0], ge};
            rem_next = ge ? diff[GAMES_W-1:0] : shifted[GAMES_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign quotient  = q_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

// ----- src/ucs_sqrt.sv -----
// Integer square root, one root bit per cycle.
module ucs_sqrt #(
    parameter int RW = 19
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2*RW-1:0]         radicand,
    output logic [RW-1:0]           root,
    output ucs_pkg::ucs_unit_stat_t stat
);
    import ucs_pkg::*;

    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW+1:0]   r_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    always_comb
    begin
        r_sh      = {rem_reg[RW-1:0], rad_reg[2*RW-1:2*RW-2]};
        trial     = {root_reg, 2'b01};
        ge        = r_sh >= trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[2*RW-3:0], 2'b00};
            rem_next  = ge ? (r_sh - trial) : r_sh;
            root_next = {root_reg[RW-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

// ----- src/ucs_ln.sv -----
// Fixed-point natural log of the play total by repeated squaring.
module ucs_ln #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ucs_pkg::TOTAL_W-1:0]    total,
    output logic [FRAC_BITS+4:0]           ln_val,
    output ucs_pkg::ucs_unit_stat_t        stat
);
    import ucs_pkg::*;

    localparam int LN_W     = FRAC_BITS + 5;
    localparam int LN_SHIFT = 104 - FRAC_BITS - L_W;
    localparam int ACC_W    = LN2_W + 1;

    localparam logic [2:0] L_IDLE  = 3'd0;
    localparam logic [2:0] L_NORM  = 3'd1;
    localparam logic [2:0] L_SQMUL = 3'd2;
    localparam logic [2:0] L_SQUPD = 3'd3;
    localparam logic [2:0] L_MUL   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [NORM_W-1:0]     m_reg, m_next;
    logic [EXP_W-1:0]      n_reg, n_next;
    logic [2*NORM_W-1:0]   prod_reg, prod_next;
    logic [SQ_ITERS-1:0]   bits_reg, bits_next;
    logic [L_W-1:0]        l_reg, l_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [ITER_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [NORM_W:0]       sq_top;
    logic [ACC_W:0]        acc_sum;

    always_comb
    begin
        sq_top     = prod_reg[2*NORM_W-1:NORM_W-1];
        acc_sum    = {1'b0, acc_reg} + (l_reg[0] ? {2'b00, LN2_Q64} : '0);
        state_next = state_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        prod_next  = prod_reg;
        bits_next  = bits_reg;
        l_next     = l_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    if (total == '0)
                    begin
                        acc_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        m_next     = NORM_W'(total);
                        n_next     = EXP_W'(NORM_W - 1);
                        state_next = L_NORM;
                    end
                end
            end
            L_NORM:
            begin
                if (m_reg[NORM_W-1])
                begin
                    cnt_next   = '0;
                    state_next = L_SQMUL;
                end
                else
                begin
                    m_next = {m_reg[NORM_W-2:0], 1'b0};
                    n_next = n_reg - EXP_W'(1);
                end
            end
            L_SQMUL:
            begin
                prod_next  = m_reg * m_reg;
                state_next = L_SQUPD;
            end
            L_SQUPD:
            begin
                m_next    = sq_top[NORM_W] ? sq_top[NORM_W:1] : sq_top[NORM_W-1:0];
                bits_next = {bits_reg[SQ_ITERS-2:0], sq_top[NORM_W]};
                cnt_next  = cnt_reg + ITER_CNT_W'(1);
                if (cnt_reg == ITER_CNT_W'(SQ_ITERS - 1))
                begin
                    l_next     = {n_reg, bits_reg[SQ_ITERS-2:0], sq_top[NORM_W]};
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = L_MUL;
                end
                else
                begin
                    state_next = L_SQMUL;
                end
            end
            L_MUL:
            begin
                acc_next = acc_sum[ACC_W:1];
                l_next   = {1'b0, l_reg[L_W-1:1]};
                cnt_next = cnt_reg + ITER_CNT_W'(1);
                if (cnt_reg == ITER_CNT_W'(L_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
        bits_reg <= bits_next;
        l_reg    <= l_next;
        acc_reg  <= acc_next;
    end

    assign ln_val    = acc_reg[LN_SHIFT +: LN_W];
    assign stat.busy = state_reg != L_IDLE;
    assign stat.done = done_reg;
endmodule

// ----- src/ucb1_child_select_top.sv -----
// Top level of the UCB1 child select block: load, score, count ties, pick.
//
//  channel   dir  handshake        payload
//  child     in   valid/ready      games_played, games_won, minimize, last
//  result    out  valid/ready      chosen_index, tie_count
//  cfg       in   cfg_wr_en        cfg_wr_data (random_seed)
//
// Child words are taken while the block is loading. After the last word the
// selection runs: the log unit first, then for each played child the shared
// bit-serial divider and root unit (an unplayed child skips them), then tie
// counting and picking per child, and the tie modulo in the divider.
// Reset clears state, count, total, mode, seed and result valid; the child
// and score stores hold no reset value. The block takes new child words while
// a result waits in the output register; a stalled result holds the pick.
module ucb1_child_select_top #(
    parameter int MAX_CHILDREN = ucs_pkg::MAX_CHILDREN_DEF,
    parameter int FRAC_BITS    = ucs_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ucs_pkg::SEED_W-1:0]  cfg_wr_data,
    ucs_child_if.sink                   child,
    ucs_result_if.source                result
);
    import ucs_pkg::*;

    localparam int IDX_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
    localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
    localparam int LN_W  = FRAC_BITS + 5;
    localparam int RT_W  = FRAC_BITS + 3;
    localparam int SC_W  = FRAC_BITS + 4;
    localparam int DIV_W = (GAMES_W + FRAC_BITS > SEED_W) ? GAMES_W + FRAC_BITS : SEED_W;
    localparam logic [SC_W-1:0] SC_ONE = SC_W'(1) << FRAC_BITS;

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_LN_GO   = 4'd1;
    localparam logic [3:0] S_LN_WAIT = 4'd2;
    localparam logic [3:0] S_SC_RD   = 4'd3;
    localparam logic [3:0] S_SC_LAT  = 4'd4;
    localparam logic [3:0] S_SC_AVG  = 4'd5;
    localparam logic [3:0] S_SC_Q    = 4'd6;
    localparam logic [3:0] S_SC_SQ   = 4'd7;
    localparam logic [3:0] S_SC_WR   = 4'd8;
    localparam logic [3:0] S_CN_RD   = 4'd9;
    localparam logic [3:0] S_CN_CHK  = 4'd10;
    localparam logic [3:0] S_MOD_GO  = 4'd11;
    localparam logic [3:0] S_MOD_WT  = 4'd12;
    localparam logic [3:0] S_PK_RD   = 4'd13;
    localparam logic [3:0] S_PK_CHK  = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  mode_reg, mode_next;
    logic [SEED_W-1:0]     lfsr_reg, lfsr_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [SC_W-1:0]       best_reg, best_next;
    logic [CNT_W-1:0]      ties_reg, ties_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    logic [CNT_W-1:0]      pick_reg, pick_next;
    logic [SC_W-1:0]       avg_reg, avg_next;
    logic [SC_W-1:0]       cb_reg, cb_next;
    logic                  unplayed_reg, unplayed_next;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0]  out_idx_reg, out_idx_next;
    logic [TIES_OUT_W-1:0] out_ties_reg, out_ties_next;

    logic                  in_fire;
    logic                  out_fire;
    logic                  last_idx;
    logic [TOTAL_W:0]      total_sum;
    logic [SEED_W-1:0]     lfsr_step;
    logic [SC_W-1:0]       score;

    logic                  stat_we;
    logic [2*GAMES_W-1:0]  stat_rdata;
    logic [GAMES_W-1:0]    rd_played;
    logic [GAMES_W-1:0]    rd_won;
    logic [GAMES_W-1:0]    won_clamped;
    logic                  score_we;
    logic [SC_W-1:0]       score_rdata;

    logic                  ln_start;
    logic [LN_W-1:0]       ln_val;
    ucs_unit_stat_t        ln_stat;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [GAMES_W-1:0]    div_divisor;
    logic [DIV_W-1:0]      div_q;
    logic [GAMES_W-1:0]    div_rem;
    ucs_unit_stat_t        div_stat;
    logic                  sq_start;
    logic [RT_W-1:0]       sq_root;
    ucs_unit_stat_t        sq_stat;

    assign child.ready = state_reg == S_LOAD;
    assign in_fire     = child.valid && child.ready;
    assign out_fire    = out_valid_reg && result.ready;
    assign last_idx    = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign total_sum   = {1'b0, total_reg} + (TOTAL_W + 1)'(child.games_played);
    assign lfsr_step   = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign rd_played   = stat_rdata[2*GAMES_W-1:GAMES_W];
    assign rd_won      = stat_rdata[GAMES_W-1:0];
    assign won_clamped = (rd_won > rd_played) ? rd_played : rd_won;
    assign stat_we     = in_fire && (count_reg < CNT_W'(MAX_CHILDREN));
    assign score_we    = state_reg == S_SC_WR;
    assign ln_start    = state_reg == S_LN_GO;

    always_comb
    begin
        if (unplayed_reg)
        begin
            score = mode_reg ? '0 : SC_ONE;
        end
        else if (mode_reg)
        begin
            score = (avg_reg >= cb_reg) ? (avg_reg - cb_reg) : '0;
        end
        else
        begin
            score = avg_reg + cb_reg;
        end
    end

    always_comb
    begin
        div_start    = ((state_reg == S_SC_LAT) && (rd_played != '0))
                    || ((state_reg == S_SC_AVG) && div_stat.done)
                    || (state_reg == S_MOD_GO);
        div_dividend = DIV_W'(won_clamped) << FRAC_BITS;
        div_divisor  = rd_played;
        if (state_reg == S_SC_AVG)
        begin
            div_dividend = DIV_W'(ln_val) << 1;
        end
        else if (state_reg == S_MOD_GO)
        begin
            div_dividend = DIV_W'(lfsr_step);
            div_divisor  = GAMES_W'(ties_reg);
        end
        sq_start = (state_reg == S_SC_Q) && div_stat.done;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        mode_next      = mode_reg;
        lfsr_next      = lfsr_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        ties_next      = ties_reg;
        seen_next      = seen_reg;
        pick_next      = pick_reg;
        avg_next       = avg_reg;
        cb_next        = cb_reg;
        unplayed_next  = unplayed_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_ties_next  = out_ties_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg == '0)
                    begin
                        mode_next = child.minimize;
                    end
                    if (stat_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    end
                    if (child.last)
                    begin
                        state_next = S_LN_GO;
                    end
                end
            end
            S_LN_GO:
            begin
                state_next = S_LN_WAIT;
            end
            S_LN_WAIT:
            begin
                if (ln_stat.done)
                begin
                    idx_next   = '0;
                    best_next  = mode_reg ? SC_ONE : '0;
                    state_next = S_SC_RD;
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_LAT;
            end
            S_SC_LAT:
            begin
                unplayed_next = rd_played == '0;
                state_next    = (rd_played == '0) ? S_SC_WR : S_SC_AVG;
            end
            S_SC_AVG:
            begin
                if (div_stat.done)
                begin
                    avg_next   = SC_W'(div_q);
                    state_next = S_SC_Q;
                end
            end
            S_SC_Q:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SC_SQ;
                end
            end
            S_SC_SQ:
            begin
                if (sq_stat.done)
                begin
                    cb_next    = SC_W'(sq_root);
                    state_next = S_SC_WR;
                end
            end
            S_SC_WR:
            begin
                if (mode_reg ? (score < best_reg) : (score > best_reg))
                begin
                    best_next = score;
                end
                if (last_idx)
                begin
                    idx_next   = '0;
                    ties_next  = '0;
                    state_next = S_CN_RD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SC_RD;
                end
            end
            S_CN_RD:
            begin
                state_next = S_CN_CHK;
            end
            S_CN_CHK:
            begin
                if (score_rdata == best_reg)
                begin
                    ties_next = ties_reg + CNT_W'(1);
                end
                if (last_idx)
                begin
                    state_next = S_MOD_GO;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_CN_RD;
                end
            end
            S_MOD_GO:
            begin
                lfsr_next  = lfsr_step;
                state_next = S_MOD_WT;
            end
            S_MOD_WT:
            begin
                if (div_stat.done)
                begin
                    pick_next  = CNT_W'(div_rem);
                    seen_next  = '0;
                    idx_next   = '0;
                    state_next = S_PK_RD;
                end
            end
            S_PK_RD:
            begin
                state_next = S_PK_CHK;
            end
            S_PK_CHK:
            begin
                if ((score_rdata == best_reg) && (seen_reg == pick_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if (score_rdata == best_reg)
                    begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_PK_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = IDX_OUT_W'(idx_reg);
                    out_ties_next  = TIES_OUT_W'(ties_reg);
                    count_next     = '0;
                    total_next     = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (cfg_wr_en)
        begin
            lfsr_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            total_reg     <= '0;
            mode_reg      <= 1'b0;
            lfsr_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            mode_reg      <= mode_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        ties_reg     <= ties_next;
        seen_reg     <= seen_next;
        pick_reg     <= pick_next;
        avg_reg      <= avg_next;
        cb_reg       <= cb_next;
        unplayed_reg <= unplayed_next;
        out_idx_reg  <= out_idx_next;
        out_ties_reg <= out_ties_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.chosen_index = out_idx_reg;
    assign result.tie_count    = out_ties_reg;

    ucs_ram #(
        .WIDTH (2 * GAMES_W),
        .DEPTH (MAX_CHILDREN)
    ) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({child.games_played, child.games_won}),
        .raddr (idx_reg),
        .rdata (stat_rdata)
    );

    ucs_ram #(
        .WIDTH (SC_W),
        .DEPTH (MAX_CHILDREN)
    ) u_score_ram (
        .clk   (clk),
        .we    (score_we),
        .waddr (idx_reg),
        .wdata (score),
        .raddr (idx_reg),
        .rdata (score_rdata)
    );

    ucs_ln #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ln_start),
        .total  (total_reg),
        .ln_val (ln_val),
        .stat   (ln_stat)
    );

    ucs_div #(
        .DW (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    ucs_sqrt #(
        .RW (RT_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ((2 * RT_W)'(div_q) << FRAC_BITS),
        .root     (sq_root),
        .stat     (sq_stat)
    );

`ifndef NO_ASSERTIONS
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_sqrt_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        sq_start |-> !sq_stat.busy)
        else $error("root unit started while busy");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PK_CHK) |-> (seen_reg <= pick_reg) && (pick_reg < ties_reg))
        else $error("tie pick ran past the tie count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CHILDREN))
        else $error("child count above store depth");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LN_WAIT) |-> !child.ready)
        else $error("child word accepted during selection");
`endif
endmodule
